FILE: rtl/core/pvp_pkg.sv
package pvp_pkg;

	// field and datapath widths
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 64;
	localparam int MAG_W     = 63;
	localparam int DIVISOR_W = 32;
	localparam int DIV_STEPS = MAG_W;
	localparam int SIZE_W    = 13;
	localparam int SUM_W     = MAG_W + 2;
	localparam int T_W       = 42;
	localparam int VP_W      = T_W + SIZE_W + 1;

	// fixed-point constants
	localparam logic signed [COORD_W-1:0] ONE_Q16        = 32'sd65536;
	localparam logic [DIVISOR_W-1:0]      NO_DIV_DIVISOR = 32'd65536;
	localparam logic signed [T_W-1:0]     T_MAX          = 42'sd1099511627776;
	localparam logic signed [T_W-1:0]     T_MIN          = -42'sd1099511627776;
	localparam logic signed [COORD_W-1:0] SAT_MAX        = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] SAT_MIN        = 32'sh80000000;

	// register reset values
	localparam logic signed [COORD_W-1:0] SCALE_RESET  = 32'sd65536;
	localparam logic [SIZE_W-1:0]         WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0]         HEIGHT_RESET = 13'd480;

	// register indexes
	typedef enum logic [1:0] {
		CFG_X_SCALE     = 2'd0,
		CFG_Y_SCALE     = 2'd1,
		CFG_VIEW_WIDTH  = 2'd2,
		CFG_VIEW_HEIGHT = 2'd3
	} cfg_idx_t;

	// input beat
	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic signed [COORD_W-1:0] vert_z;
	} vertex_t;

	// output beat
	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      depth_zero;
	} screen_t;

	// divider operands, magnitudes with quotient signs
	typedef struct packed {
		logic [MAG_W-1:0]     mag_x;
		logic [MAG_W-1:0]     mag_y;
		logic [DIVISOR_W-1:0] divisor;
		logic                 neg_x;
		logic                 neg_y;
		logic                 depth_zero;
	} scaled_t;

	// divider results
	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
		logic             depth_zero;
	} quot_t;

endpackage

FILE: rtl/core/perspective_vertex_project_unit.sv
// Perspective projection and viewport mapping of camera-space vertices in Q16.16. One vertex
// is taken per clock while in_stall is low, and one screen beat comes out per vertex, in
// order, through projection multiply and operand set-up, a fully pipelined restoring divider
// (one quotient bit per stage, x and y side by side), offset, clamp and viewport multiply,
// and the output register. A depth of zero divides by one instead (the scaled value is taken
// as is) and raises depth_zero. in_stall comes from a register: it rises only when the output
// is stalled and a one-beat skid slot has filled, and the whole pipeline then holds. The
// configuration port is always ready; registers are meant to be written while no vertex is in
// flight.
module perspective_vertex_project_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  pvp_pkg::vertex_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output pvp_pkg::screen_t             out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  pvp_pkg::cfg_idx_t            cfg_index,
	input  logic [pvp_pkg::COORD_W-1:0]  cfg_data
);
	import pvp_pkg::*;

	logic signed [COORD_W-1:0] x_scale_q;
	logic signed [COORD_W-1:0] y_scale_q;
	logic [SIZE_W-1:0]         view_width_q;
	logic [SIZE_W-1:0]         view_height_q;

	logic    adv;
	logic    scl_valid;
	scaled_t scl_data;
	logic    div_valid;
	quot_t   div_data;
	logic    res_valid;
	screen_t res_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q     <= SCALE_RESET;
			y_scale_q     <= SCALE_RESET;
			view_width_q  <= WIDTH_RESET;
			view_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_X_SCALE:     x_scale_q     <= cfg_data;
				CFG_Y_SCALE:     y_scale_q     <= cfg_data;
				CFG_VIEW_WIDTH:  view_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_VIEW_HEIGHT: view_height_q <= cfg_data[SIZE_W-1:0];
				default:         ;
			endcase
		end
	end

	// input beat is taken whenever the pipeline moves
	assign in_stall = !adv;

	pvp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.x_scale   (x_scale_q),
		.y_scale   (y_scale_q),
		.out_valid (scl_valid),
		.out_data  (scl_data)
	);

	pvp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (scl_valid),
		.in_data   (scl_data),
		.out_valid (div_valid),
		.out_data  (div_data)
	);

	pvp_viewport u_viewport (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (div_valid),
		.in_data     (div_data),
		.view_width  (view_width_q),
		.view_height (view_height_q),
		.res_valid   (res_valid),
		.res_data    (res_data)
	);

	pvp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_data  (res_data),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/core/pvp_scale.sv
module pvp_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  pvp_pkg::vertex_t                   in_data,
	input  logic signed [pvp_pkg::COORD_W-1:0] x_scale,
	input  logic signed [pvp_pkg::COORD_W-1:0] y_scale,
	output logic                               out_valid,
	output pvp_pkg::scaled_t                   out_data
);
	import pvp_pkg::*;

	logic                      vld_s1;
	logic signed [PROD_W-1:0]  prod_x_s1;
	logic signed [PROD_W-1:0]  prod_y_s1;
	logic signed [COORD_W-1:0] wz_s1;
	logic                      vld_s2;
	scaled_t                   op_s2;
	scaled_t                   op_d;
	logic [PROD_W-1:0]         neg_px;
	logic [PROD_W-1:0]         neg_py;
	logic [COORD_W-1:0]        neg_w;

	// stage 1: projection multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= in_data.vert_x * x_scale;
			prod_y_s1 <= in_data.vert_y * y_scale;
			wz_s1     <= in_data.vert_z;
		end
	end

	// magnitudes, quotient signs and divisor choice
	always_comb begin
		neg_px = -prod_x_s1;
		neg_py = -prod_y_s1;
		neg_w  = -wz_s1;
		op_d.mag_x      = prod_x_s1[PROD_W-1] ? neg_px[MAG_W-1:0] : prod_x_s1[MAG_W-1:0];
		op_d.mag_y      = prod_y_s1[PROD_W-1] ? neg_py[MAG_W-1:0] : prod_y_s1[MAG_W-1:0];
		op_d.depth_zero = (wz_s1 == '0);
		if (op_d.depth_zero) begin
			op_d.divisor = NO_DIV_DIVISOR;
		end else if (wz_s1[COORD_W-1]) begin
			op_d.divisor = neg_w;
		end else begin
			op_d.divisor = wz_s1;
		end
		// y flips sign on the way to the screen
		op_d.neg_x = prod_x_s1[PROD_W-1] ^ wz_s1[COORD_W-1];
		op_d.neg_y = ~(prod_y_s1[PROD_W-1] ^ wz_s1[COORD_W-1]);
	end

	// stage 2: divider operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = op_s2;

endmodule

FILE: rtl/core/pvp_divider.sv
module pvp_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  pvp_pkg::scaled_t in_data,
	output logic             out_valid,
	output pvp_pkg::quot_t   out_data
);
	import pvp_pkg::*;

	// partial remainder plus a word that shifts dividend bits out and quotient bits in
	typedef struct packed {
		logic [DIVISOR_W-1:0] rem;
		logic [MAG_W-1:0]     nq;
	} lane_t;

	typedef struct packed {
		logic [DIVISOR_W-1:0] divisor;
		lane_t                lx;
		lane_t                ly;
		logic                 neg_x;
		logic                 neg_y;
		logic                 depth_zero;
	} stage_t;

	// one restoring step
	function automatic lane_t div_step(lane_t cur, logic [DIVISOR_W-1:0] d);
		logic [DIVISOR_W:0] trial;
		lane_t              nxt;
		trial = {cur.rem, cur.nq[MAG_W-1]} - {1'b0, d};
		if (!trial[DIVISOR_W]) begin
			nxt.rem = trial[DIVISOR_W-1:0];
			nxt.nq  = {cur.nq[MAG_W-2:0], 1'b1};
		end else begin
			nxt.rem = {cur.rem[DIVISOR_W-2:0], cur.nq[MAG_W-1]};
			nxt.nq  = {cur.nq[MAG_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// div_s[k] holds the state after k+1 steps
	stage_t div_s [DIV_STEPS];
	logic   vld_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		stage_t src;
		logic   src_vld;

		if (k == 0) begin : g_head
			assign src = '{
				divisor:    in_data.divisor,
				lx:         '{rem: '0, nq: in_data.mag_x},
				ly:         '{rem: '0, nq: in_data.mag_y},
				neg_x:      in_data.neg_x,
				neg_y:      in_data.neg_y,
				depth_zero: in_data.depth_zero
			};
			assign src_vld = in_valid;
		end else begin : g_tail
			assign src     = div_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k].divisor    <= src.divisor;
				div_s[k].lx         <= div_step(src.lx, src.divisor);
				div_s[k].ly         <= div_step(src.ly, src.divisor);
				div_s[k].neg_x      <= src.neg_x;
				div_s[k].neg_y      <= src.neg_y;
				div_s[k].depth_zero <= src.depth_zero;
			end
		end
	end

	// quotients after the last step
	assign out_valid           = vld_s[DIV_STEPS-1];
	assign out_data.mag_x      = div_s[DIV_STEPS-1].lx.nq;
	assign out_data.mag_y      = div_s[DIV_STEPS-1].ly.nq;
	assign out_data.neg_x      = div_s[DIV_STEPS-1].neg_x;
	assign out_data.neg_y      = div_s[DIV_STEPS-1].neg_y;
	assign out_data.depth_zero = div_s[DIV_STEPS-1].depth_zero;

endmodule

FILE: rtl/core/pvp_viewport.sv
module pvp_viewport (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  pvp_pkg::quot_t              in_data,
	input  logic [pvp_pkg::SIZE_W-1:0]  view_width,
	input  logic [pvp_pkg::SIZE_W-1:0]  view_height,
	output logic                        res_valid,
	output pvp_pkg::screen_t            res_data
);
	import pvp_pkg::*;

	// signed ndc value plus one, clamped
	function automatic logic signed [T_W-1:0] to_t(logic [MAG_W-1:0] mag, logic neg);
		logic signed [SUM_W-1:0] m;
		logic signed [SUM_W-1:0] s;
		m = $signed({{(SUM_W-MAG_W){1'b0}}, mag});
		s = ONE_Q16 + (neg ? -m : m);
		if (s > T_MAX) begin
			return T_MAX;
		end else if (s < T_MIN) begin
			return T_MIN;
		end
		return s[T_W-1:0];
	endfunction

	// halve with floor, then clamp to 32 bits
	function automatic logic signed [COORD_W-1:0] sat_half(logic signed [VP_W-1:0] prod);
		logic signed [VP_W-1:0] r;
		r = prod >>> 1;
		if (r > SAT_MAX) begin
			return SAT_MAX;
		end else if (r < SAT_MIN) begin
			return SAT_MIN;
		end
		return r[COORD_W-1:0];
	endfunction

	logic                    vld_s1;
	logic signed [T_W-1:0]   t_x_s1;
	logic signed [T_W-1:0]   t_y_s1;
	logic                    dz_s1;
	logic                    vld_s2;
	logic signed [VP_W-1:0]  prod_x_s2;
	logic signed [VP_W-1:0]  prod_y_s2;
	logic                    dz_s2;

	// stage 1: sign, offset and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_x_s1 <= to_t(in_data.mag_x, in_data.neg_x);
			t_y_s1 <= to_t(in_data.mag_y, in_data.neg_y);
			dz_s1  <= in_data.depth_zero;
		end
	end

	// stage 2: scale by viewport size
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s2 <= t_x_s1 * $signed({1'b0, view_width});
			prod_y_s2 <= t_y_s1 * $signed({1'b0, view_height});
			dz_s2     <= dz_s1;
		end
	end

	// final result, registered in the output buffer
	assign res_valid           = vld_s2;
	assign res_data.screen_x   = sat_half(prod_x_s2);
	assign res_data.screen_y   = sat_half(prod_y_s2);
	assign res_data.depth_zero = dz_s2;

endmodule

FILE: rtl/core/pvp_outbuf.sv
module pvp_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  pvp_pkg::screen_t res_data,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_stall,
	output pvp_pkg::screen_t out_data
);
	import pvp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	screen_t out_q;
	screen_t skid_q;

	// pipeline moves whenever the skid slot is free
	assign adv       = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || !out_stall) begin
			out_q <= res_data;
		end else if (res_valid) begin
			skid_q <= res_data;
		end
	end

	// a filled skid slot always sits behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output is empty");

	// a skid beat waits as long as the output is stalled
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_stall |=> skid_valid_q && $stable(skid_q))
		else $error("skid beat lost during stall");

	// a drained skid beat becomes the next output beat
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q && out_valid_q && out_q == $past(skid_q))
		else $error("skid beat not moved to output");

endmodule

FILE: tb/tb_perspective_vertex_project_unit.sv
`timescale 1ns / 1ps
module tb_perspective_vertex_project_unit;
	import pvp_pkg::*;

	// handy coordinate and pixel values, Q16.16
	localparam logic signed [COORD_W-1:0] C_MAX     = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] C_MIN     = 32'sh80000000;
	localparam logic signed [COORD_W-1:0] C_ONE     = ONE_Q16;
	localparam logic signed [COORD_W-1:0] C_NEG_ONE = -32'sd65536;
	localparam logic signed [COORD_W-1:0] C_HALF    = 32'sh00008000;
	localparam logic signed [COORD_W-1:0] C_LSB_NEG = -32'sd1;
	localparam logic signed [COORD_W-1:0] PX_240    = 32'sh00f00000;
	localparam logic signed [COORD_W-1:0] PX_320    = 32'sh01400000;
	localparam logic signed [COORD_W-1:0] PX_360    = 32'sh01680000;
	localparam logic signed [COORD_W-1:0] PX_480    = 32'sh01e00000;
	localparam logic signed [COORD_W-1:0] PX_640    = 32'sh02800000;
	localparam screen_t                   NO_LIT    = '0;

	// one directed vertex, with a typed-in screen beat where it is obvious
	typedef struct {
		vertex_t vtx;
		bit      typed;
		screen_t want;
	} probe_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	vertex_t             in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	screen_t             out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_X_SCALE;
	logic [COORD_W-1:0]  cfg_data  = '0;

	// shadow of the projection registers
	longint proj_x_scale = SCALE_RESET;
	longint proj_y_scale = SCALE_RESET;
	longint vp_width     = WIDTH_RESET;
	longint vp_height    = HEIGHT_RESET;

	screen_t expected_screen [$];
	screen_t due;
	int      n_fail     = 0;
	int      stall_hold = 0;
	bit      quiet      = 1'b0;
	bit      gappy      = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	perspective_vertex_project_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scaled coordinate over w, or undivided when w is zero, truncated toward zero
	function automatic longint ndc_of(longint coord, longint scale, longint w);
		longint p;
		p = coord * scale;
		if (w != 0)
			return p / w;
		return p / longint'(ONE_Q16);
	endfunction

	// offset by one, clamp, scale by half the viewport size with floor, saturate
	function automatic logic signed [COORD_W-1:0] to_pixels(longint ndc, longint size);
		longint t;
		longint prod;
		longint r;
		t = ndc + longint'(ONE_Q16);
		if (t > T_MAX)
			t = T_MAX;
		if (t < T_MIN)
			t = T_MIN;
		prod = t * size;
		r = prod >>> 1;
		if (r > SAT_MAX)
			r = SAT_MAX;
		if (r < SAT_MIN)
			r = SAT_MIN;
		return r[COORD_W-1:0];
	endfunction

	function automatic screen_t project_vertex(vertex_t v);
		longint  vx;
		longint  vy;
		longint  vz;
		screen_t s;
		vx = longint'(signed'(v.vert_x));
		vy = longint'(signed'(v.vert_y));
		vz = longint'(signed'(v.vert_z));
		s.screen_x   = to_pixels(ndc_of(vx, proj_x_scale, vz), vp_width);
		s.screen_y   = to_pixels(-ndc_of(vy, proj_y_scale, vz), vp_height);
		s.depth_zero = (vz == 0);
		return s;
	endfunction

	function automatic logic [COORD_W-1:0] pick_extreme();
		unique case ($urandom_range(0, 6))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			3: return C_LSB_NEG;
			4: return 32'd1;
			5: return C_ONE;
			default: return C_NEG_ONE;
		endcase
	endfunction

	// projection factor around 0.25 to 4.0 with random sign
	function automatic logic [COORD_W-1:0] rand_scale();
		int mag;
		mag = int'($urandom_range(1 << 14, 1 << 18));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		int      zm;
		int      kind;
		kind = $urandom_range(0, 9);
		v.vert_x = $urandom();
		v.vert_y = $urandom();
		v.vert_z = $urandom();
		if (kind <= 5) begin
			// roughly inside the frustum, sometimes behind the camera
			zm = int'($urandom_range(256, 100 << 16));
			v.vert_z = ($urandom_range(0, 3) == 0) ? -zm : zm;
			v.vert_x = int'($urandom_range(0, 2 * zm)) - zm;
			v.vert_y = int'($urandom_range(0, 2 * zm)) - zm;
		end else if (kind == 6) begin
			v.vert_z = '0;
		end else if (kind == 7) begin
			v.vert_z = $urandom_range(0, 1) ? int'($urandom_range(1, 255))
				: -int'($urandom_range(1, 255));
		end else if (kind == 8) begin
			v.vert_x = pick_extreme();
			v.vert_y = pick_extreme();
			v.vert_z = pick_extreme();
		end
		return v;
	endfunction

	// present one vertex beat, hold it until taken, then queue its screen beat
	task automatic send_vertex(input vertex_t v, input bit typed, input screen_t want);
		if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= v;
		do @(posedge clk); while (in_stall);
		expected_screen.insert(expected_screen.size(), typed ? want : project_vertex(v));
	endtask

	// stop sending until every screen beat is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_screen.size() != 0) @(posedge clk);
	endtask

	// write all four registers back to back, block idle
	task automatic program_view(input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
			input logic [COORD_W-1:0] wd, input logic [COORD_W-1:0] ht);
		cfg_idx_t           order [4];
		logic [COORD_W-1:0] vals [4];
		order = '{CFG_X_SCALE, CFG_Y_SCALE, CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT};
		vals  = '{xs, ys, wd, ht};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			unique case (order[i])
				CFG_X_SCALE:     proj_x_scale = longint'(signed'(vals[i]));
				CFG_Y_SCALE:     proj_y_scale = longint'(signed'(vals[i]));
				CFG_VIEW_WIDTH:  vp_width     = longint'(vals[i][SIZE_W-1:0]);
				CFG_VIEW_HEIGHT: vp_height    = longint'(vals[i][SIZE_W-1:0]);
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// output stall in bursts, with free runs of varied length between them
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (!out_stall && $urandom_range(0, 2) == 0) begin
			out_stall  <= 1'b1;
			stall_hold <= $urandom_range(0, 14);
		end else begin
			out_stall  <= 1'b0;
			stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 20);
		end
	end

	// screen beat check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_screen.size() == 0) begin
				$error("screen beat with nothing expected: x %0d y %0d depth_zero %0b",
					out_data.screen_x, out_data.screen_y, out_data.depth_zero);
				n_fail++;
			end else begin
				due = expected_screen.pop_front();
				if (out_data.screen_x !== due.screen_x) begin
					$error("screen_x: expected %0d, got %0d", due.screen_x, out_data.screen_x);
					n_fail++;
				end
				if (out_data.screen_y !== due.screen_y) begin
					$error("screen_y: expected %0d, got %0d", due.screen_y, out_data.screen_y);
					n_fail++;
				end
				if (out_data.depth_zero !== due.depth_zero) begin
					$error("depth_zero: expected %0b, got %0b", due.depth_zero,
						out_data.depth_zero);
					n_fail++;
				end
			end
		end
	end

	initial begin
		probe_t dir_tab [16];
		// reset settings: unit scales, 640 by 480 viewport
		dir_tab = '{
			'{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{PX_320, PX_240, 1'b1}},
			'{'{32'sd0, 32'sd0, C_ONE}, 1'b1, '{PX_320, PX_240, 1'b0}},
			'{'{C_ONE, C_ONE, C_ONE}, 1'b1, '{PX_640, 32'sd0, 1'b0}},
			'{'{C_LSB_NEG, C_LSB_NEG, C_LSB_NEG}, 1'b1, '{PX_640, 32'sd0, 1'b0}},
			'{'{C_MAX, C_MIN, 32'sd1}, 1'b1, '{SAT_MAX, SAT_MAX, 1'b0}},
			'{'{C_MIN, C_MAX, 32'sd1}, 1'b1, '{SAT_MIN, SAT_MIN, 1'b0}},
			'{'{C_MAX, C_MAX, 32'sd0}, 1'b1, '{SAT_MAX, SAT_MIN, 1'b1}},
			'{'{C_MIN, C_MIN, 32'sd0}, 1'b1, '{SAT_MIN, SAT_MAX, 1'b1}},
			'{'{C_ONE, C_NEG_ONE, C_NEG_ONE}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
			'{'{C_NEG_ONE, C_ONE, C_NEG_ONE}, 1'b1, '{PX_640, PX_480, 1'b0}},
			'{'{C_MAX, C_MAX, C_MIN}, 1'b0, NO_LIT},
			'{'{C_MIN, C_MIN, C_MIN}, 1'b0, NO_LIT},
			'{'{C_MIN, C_MIN, C_MAX}, 1'b0, NO_LIT},
			'{'{32'sd0, 32'sd0, 32'sd1}, 1'b1, '{PX_320, PX_240, 1'b0}},
			'{'{32'sd0, 32'sd0, C_LSB_NEG}, 1'b1, '{PX_320, PX_240, 1'b0}},
			'{'{C_HALF, -C_HALF, C_ONE}, 1'b1, '{PX_480, PX_360, 1'b0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed vertices against the reset register values
		foreach (dir_tab[i])
			send_vertex(dir_tab[i].vtx, dir_tab[i].typed, dir_tab[i].want);
		drain_results();

		// random vertices under a series of projection settings
		for (int ph = 0; ph < 9; ph++) begin
			gappy = $urandom_range(0, 1);
			case (ph)
				0: program_view(C_MAX, C_MIN, 32'd4096, 32'd1);
				1: program_view(C_MIN, C_MAX, 32'd1, 32'd4096);
				// zero viewport sizes
				2: program_view(32'd0, 32'd0, 32'd0, 32'd0);
				3: program_view($urandom(), $urandom(), 32'h1fff, 32'h1fff);
				// upper data bits on the size registers are dropped
				4: program_view(rand_scale(), rand_scale(), $urandom(), $urandom());
				// odd sizes make the floor visible
				5: program_view(C_ONE, C_ONE, 32'd639, 32'd479);
				default: program_view(rand_scale(), rand_scale(), $urandom_range(1, 4096),
					$urandom_range(1, 4096));
			endcase
			if (ph == 8)
				quiet = 1'b1;
			for (int k = 0; k < 110; k++) begin
				send_vertex(rand_vertex(), 1'b0, NO_LIT);
				if (ph == 5 && k == 55)
					drain_results();
			end
			drain_results();
		end

		// let any stray beat show up
		repeat (100) @(posedge clk);
		if (expected_screen.size() != 0) begin
			$error("%0d screen beats never arrived", expected_screen.size());
			n_fail++;
		end
		if (n_fail == 0)
			$display("PASS perspective_vertex_project_unit");
		else
			$display("FAIL perspective_vertex_project_unit");
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("FAIL perspective_vertex_project_unit");
		$finish;
	end

endmodule
